// File: design/float_to_pcm16_converter_unit_macros.svh
// assertion macros for the float to pcm16 converter
`ifndef FLOAT_TO_PCM16_CONVERTER_UNIT_MACROS_SVH
`define FLOAT_TO_PCM16_CONVERTER_UNIT_MACROS_SVH

// same-cycle implication
`define F2P_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("f2p assertion failed");

// next-cycle implication
`define F2P_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("f2p assertion failed");

`endif

// File: design/f2p_pkg.sv
// ---------------------------------------------------------------------------
// f2p_pkg
// shared types and constants of the float to pcm16 converter
// ---------------------------------------------------------------------------
package f2p_pkg;

  localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;
  localparam logic [7:0]  EXP_ONE      = 8'd127;  // biased exponent of 1.0
  localparam logic [7:0]  EXP_HALF     = 8'd126;
  localparam logic [6:0]  SHIFT_CAP    = 7'd42;
  localparam logic [27:0] ONE_FX       = 28'h400_0000;  // 1.0 at 2^-26
  localparam logic [15:0] PCM_MAX      = 16'h7FFF;
  localparam logic [15:0] PCM_MIN      = 16'h8000;

  typedef struct packed {
    logic [15:0] pcm_sample;
    logic        clipped;
  } f2p_res_t;

endpackage

// File: design/f2p_if.sv
// ---------------------------------------------------------------------------
// f2p_in_if / f2p_out_if
// valid/ready channels of the float to pcm16 converter
// ---------------------------------------------------------------------------
interface f2p_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] sample_bits;
  logic        block_end;

  modport source (output valid, output sample_bits, output block_end, input ready);
  modport sink   (input valid, input sample_bits, input block_end, output ready);
endinterface

interface f2p_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pcm_sample;
  logic               clipped;
  logic               block_end_out;

  modport source (output valid, output pcm_sample, output clipped,
                  output block_end_out, input ready);
  modport sink   (input valid, input pcm_sample, input clipped,
                  input block_end_out, output ready);
endinterface

// File: design/float_to_pcm16_converter_unit.sv
// a sample word passes through the input register and then the result register before its pcm word is offered
// throughput: one word per cycle while the output word is being taken, set by the single conversion stage
// input register feeds the converter, the result register holds the pcm word
// a full pipeline still takes a word whenever the output word is being taken
// reset (rst, synchronous, active high) empties both stages; no other state
// ---------------------------------------------------------------------------
// float_to_pcm16_converter_unit
// binary32 audio sample to signed 16-bit pcm, with clip flag and block mark
// ---------------------------------------------------------------------------
`include "float_to_pcm16_converter_unit_macros.svh"

module float_to_pcm16_converter_unit (
  input  logic       clk,
  input  logic       rst,
  f2p_in_if.sink     samples,
  f2p_out_if.source  pcm
);

  // input stage
  logic        s1_valid;
  logic [31:0] s1_bits;
  logic        s1_end;
  // result stage
  logic        s2_valid;
  f2p_pkg::f2p_res_t s2_res;
  logic        s2_end;

  f2p_pkg::f2p_res_t conv_res;
  logic        s2_load;
  logic        s1_load;

  // result stage refills when empty or when its word leaves now
  assign s2_load = !s2_valid || pcm.ready;
  // input stage takes a word when empty or when it moves on
  assign s1_load = !s1_valid || s2_load;
  assign samples.ready = s1_load;

  f2p_conv u_conv (
    .sample_bits (s1_bits),
    .res         (conv_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_load) s1_valid <= samples.valid;
      if (s2_load) s2_valid <= s1_valid;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (s1_load && samples.valid) begin
      s1_bits <= samples.sample_bits;
      s1_end  <= samples.block_end;
    end
    if (s2_load && s1_valid) begin
      s2_res <= conv_res;
      s2_end <= s1_end;
    end
  end

  assign pcm.valid         = s2_valid;
  assign pcm.pcm_sample    = s2_res.pcm_sample;
  assign pcm.clipped       = s2_res.clipped;
  assign pcm.block_end_out = s2_end;

  // an accepted word always lands in the input stage
  `F2P_ASSERT_NEXT(a_accept_lands, clk, rst, samples.valid && samples.ready, s1_valid)
  // a word in the input stage is never overwritten while it waits
  `F2P_ASSERT_NOW(a_no_overrun, clk, rst, s1_valid && !s2_load, !samples.ready)
  // a clipped word sits at one end of the range
  `F2P_ASSERT_NOW(a_clip_ends, clk, rst, pcm.valid && pcm.clipped,
    pcm.pcm_sample == f2p_pkg::PCM_MAX || pcm.pcm_sample == f2p_pkg::PCM_MIN)

endmodule

// File: design/f2p_conv.sv
// ---------------------------------------------------------------------------
// f2p_conv
// combinational binary32 + 1.0 rounding, scale, truncate and clamp
// ---------------------------------------------------------------------------
module f2p_conv (
  input  logic [31:0]       sample_bits,
  output f2p_pkg::f2p_res_t res
);

  logic        neg;
  logic [7:0]  bexp;
  logic [23:0] mant;
  logic [6:0]  k;
  logic [65:0] shifted;
  logic [25:0] xv;
  logic        sticky;
  logic [27:0] s;
  logic        sum_lt_one;
  logic [25:0] q;
  logic        rup;
  logic [25:0] qr;
  logic [16:0] t_far;
  logic [26:0] mshift;
  logic [26:0] ov;
  logic [16:0] t_near;
  logic        near_neg;
  logic [16:0] tval;
  logic        lo;
  logic        hi;

  always_comb begin
    neg  = sample_bits[31];
    bexp = sample_bits[30:23];
    mant = {bexp != 8'd0, sample_bits[22:0]};

    // right shift that aligns the addend to units of 2^-26
    if (bexp == 8'd0) begin
      k = f2p_pkg::SHIFT_CAP;
    end else if (bexp <= (f2p_pkg::EXP_HALF - 8'(f2p_pkg::SHIFT_CAP))) begin
      k = f2p_pkg::SHIFT_CAP;
    end else begin
      k = 7'(f2p_pkg::EXP_HALF - bexp);
    end
    shifted = {mant, 2'b00, 40'd0} >> k;
    xv      = shifted[65:40];
    sticky  = |shifted[39:0];

    if (!neg) begin
      s = f2p_pkg::ONE_FX + {2'b00, xv};
    end else begin
      s = f2p_pkg::ONE_FX - {2'b00, xv} - {27'd0, sticky};
    end
    sum_lt_one = (s[27:26] == 2'b00);

    // round to 24 significant bits, nearest even
    if (sum_lt_one) begin
      q   = s[27:2];
      rup = s[1] & (s[0] | sticky | q[0]);
    end else begin
      q   = {1'b0, s[27:3]};
      rup = s[2] & ((|s[1:0]) | sticky | q[0]);
    end
    qr = q + {25'd0, rup};
    if (sum_lt_one) begin
      t_far = 17'(qr >> 9);
    end else begin
      t_far = 17'(qr >> 8);
    end

    // negative samples in [0.5, 2): the sum is exact
    if (bexp == f2p_pkg::EXP_ONE) begin
      mshift = {mant, 3'b000};
    end else begin
      mshift = {1'b0, mant, 2'b00};
    end
    near_neg = 1'b0;
    ov       = 27'd0;
    if (mshift <= f2p_pkg::ONE_FX[26:0]) begin
      t_near = 17'((f2p_pkg::ONE_FX[26:0] - mshift) >> 11);
    end else begin
      ov       = mshift - f2p_pkg::ONE_FX[26:0];
      t_near   = 17'd0;
      near_neg = (ov >= 27'd2048);
    end

    lo   = 1'b0;
    hi   = 1'b0;
    tval = t_far;
    if (bexp == f2p_pkg::EXP_ALL_ONES) begin
      if (neg || (sample_bits[22:0] != 23'd0)) lo = 1'b1;
      else hi = 1'b1;
    end else if (!neg && (bexp >= f2p_pkg::EXP_ONE)) begin
      hi = 1'b1;
    end else if (neg && (bexp > f2p_pkg::EXP_ONE)) begin
      lo = 1'b1;
    end else if (neg && (bexp >= f2p_pkg::EXP_HALF)) begin
      lo   = near_neg;
      tval = t_near;
    end else begin
      hi = tval[16];
    end

    res.clipped = lo | hi;
    if (lo) begin
      res.pcm_sample = f2p_pkg::PCM_MIN;
    end else if (hi) begin
      res.pcm_sample = f2p_pkg::PCM_MAX;
    end else begin
      res.pcm_sample = tval[15:0] ^ f2p_pkg::PCM_MIN;
    end
  end

endmodule
